// ===== hw/rtl/rpv_pkg.sv =====
// ----------------------------------------------------------------------------
// rpv_pkg: shared types and constants for the vertex rotate/project pipeline
// Fixed-point widths, register indexes, CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package rpv_pkg;

    // parameter defaults
    localparam int COORD_FRAC_BITS_DEF = 12;
    localparam int ANGLE_BITS_DEF      = 16;

    // working coordinate width, wide enough for the unit shift at 20 fraction bits
    localparam int CW = 24;
    // sine and cosine width, Q2.30 plus headroom
    localparam int TW = 34;
    // low part of the split trig multiplier operand
    localparam int LOW_W = 17;

    localparam int IN_W   = 16;
    localparam int ANG_W  = 16;
    localparam int DIST_W = 15;
    localparam int SCR_W  = 13;
    localparam int OUT_W  = 16;

    localparam int CORDIC_STEPS = 24;
    localparam logic signed [TW-1:0] CORDIC_GAIN = 34'sd652032874;

    // register indexes
    localparam logic [2:0] CFG_ANGLE_Z    = 3'd0;
    localparam logic [2:0] CFG_ANGLE_X    = 3'd1;
    localparam logic [2:0] CFG_ANGLE_Y    = 3'd2;
    localparam logic [2:0] CFG_PROJ_DIST  = 3'd3;
    localparam logic [2:0] CFG_PLANE_SIZE = 3'd4;
    localparam logic [2:0] CFG_SCR_WIDTH  = 3'd5;
    localparam logic [2:0] CFG_SCR_HEIGHT = 3'd6;

    typedef struct packed {
        logic signed [TW-1:0] cos_z;
        logic signed [TW-1:0] sin_z;
        logic signed [TW-1:0] cos_x;
        logic signed [TW-1:0] sin_x;
        logic signed [TW-1:0] cos_y;
        logic signed [TW-1:0] sin_y;
    } trig_t;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [29:0] atan_turn(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rpv_sincos.sv =====
// ----------------------------------------------------------------------------
// rpv_sincos: iterative CORDIC for the three rotation angles
// One CORDIC step per cycle; recomputes all three angles on restart.
// ----------------------------------------------------------------------------
`default_nettype none

module rpv_sincos #(
    parameter int ANGLE_BITS = rpv_pkg::ANGLE_BITS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       restart,
    input  wire logic [rpv_pkg::ANG_W-1:0]  angle_z,
    input  wire logic [rpv_pkg::ANG_W-1:0]  angle_x,
    input  wire logic [rpv_pkg::ANG_W-1:0]  angle_y,
    output logic                            busy,
    output rpv_pkg::trig_t                  trig
);
    import rpv_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_ITER = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [1:0]           idx_reg, idx_next;
    logic [4:0]           step_reg, step_next;
    logic [1:0]           quad_reg, quad_next;
    logic signed [TW-1:0] x_reg, x_next;
    logic signed [TW-1:0] y_reg, y_next;
    logic signed [31:0]   z_reg, z_next;
    trig_t                trig_reg, trig_next;

    logic [ANG_W-1:0]     ang_sel;
    logic [47:0]          ang_wide;
    logic [31:0]          turn;
    logic signed [TW-1:0] dx, dy, x_it, y_it, c_res, s_res;
    logic signed [31:0]   at;

    always_comb begin
        case (idx_reg)
            2'd0:    ang_sel = angle_z;
            2'd1:    ang_sel = angle_x;
            default: ang_sel = angle_y;
        endcase
    end

    // angle as a 32-bit fraction of a turn
    assign ang_wide = {32'd0, ang_sel} << (32 - ANGLE_BITS);
    assign turn     = ang_wide[31:0];

    assign dx   = y_reg >>> step_reg;
    assign dy   = x_reg >>> step_reg;
    assign at   = $signed({2'b00, atan_turn(step_reg)});
    assign x_it = (z_reg >= 0) ? x_reg - dx : x_reg + dx;
    assign y_it = (z_reg >= 0) ? y_reg + dy : y_reg - dy;

    always_comb begin
        case (quad_reg)
            2'd0:    begin c_res = x_it;  s_res = y_it;  end
            2'd1:    begin c_res = -y_it; s_res = x_it;  end
            2'd2:    begin c_res = -x_it; s_res = -y_it; end
            default: begin c_res = y_it;  s_res = -x_it; end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        quad_next  = quad_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        trig_next  = trig_reg;
        case (state_reg)
            ST_LOAD: begin
                x_next     = CORDIC_GAIN;
                y_next     = '0;
                z_next     = $signed({2'b00, turn[29:0]});
                quad_next  = turn[31:30];
                step_next  = '0;
                state_next = ST_ITER;
            end
            ST_ITER: begin
                x_next    = x_it;
                y_next    = y_it;
                z_next    = (z_reg >= 0) ? z_reg - at : z_reg + at;
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(CORDIC_STEPS - 1)) begin
                    case (idx_reg)
                        2'd0: begin
                            trig_next.cos_z = c_res;
                            trig_next.sin_z = s_res;
                        end
                        2'd1: begin
                            trig_next.cos_x = c_res;
                            trig_next.sin_x = s_res;
                        end
                        default: begin
                            trig_next.cos_y = c_res;
                            trig_next.sin_y = s_res;
                        end
                    endcase
                    if (idx_reg == 2'd2) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = ST_LOAD;
                    end
                end
            end
            default: ;
        endcase
        if (restart) begin
            idx_next   = '0;
            state_next = ST_LOAD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
        step_reg <= step_next;
        quad_reg <= quad_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        trig_reg <= trig_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign trig = trig_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rpv_rot.sv =====
// ----------------------------------------------------------------------------
// rpv_rot: two-stage plane rotation of a coordinate pair
// a' = a*c - b*s, b' = a*s + b*c, rounded from Q.30; third coordinate rides along.
// ----------------------------------------------------------------------------
`default_nettype none

module rpv_rot (
    input  wire logic                             aclk,
    input  wire logic                             adv,
    input  wire logic signed [rpv_pkg::CW-1:0]    a_in,
    input  wire logic signed [rpv_pkg::CW-1:0]    b_in,
    input  wire logic signed [rpv_pkg::CW-1:0]    p_in,
    input  wire logic signed [rpv_pkg::TW-1:0]    cos_in,
    input  wire logic signed [rpv_pkg::TW-1:0]    sin_in,
    output logic signed [rpv_pkg::CW-1:0]         a_out,
    output logic signed [rpv_pkg::CW-1:0]         b_out,
    output logic signed [rpv_pkg::CW-1:0]         p_out
);
    import rpv_pkg::*;

    localparam int HI_W = TW - LOW_W;
    localparam int PW   = CW + LOW_W + 1;
    localparam int RW   = PW + LOW_W + 3;
    localparam logic signed [RW-1:0] RND = RW'(1) <<< 29;

    logic signed [HI_W-1:0]  c_hi, s_hi;
    logic signed [LOW_W:0]   c_lo, s_lo;

    logic signed [PW-1:0] ac_hi_reg, bs_hi_reg, as_hi_reg, bc_hi_reg;
    logic signed [PW-1:0] ac_lo_reg, bs_lo_reg, as_lo_reg, bc_lo_reg;
    logic signed [CW-1:0] p_d1_reg, a_out_reg, b_out_reg, p_out_reg;
    logic signed [RW-1:0] ta_next, tb_next;

    assign c_hi = cos_in[TW-1:LOW_W];
    assign s_hi = sin_in[TW-1:LOW_W];
    assign c_lo = $signed({1'b0, cos_in[LOW_W-1:0]});
    assign s_lo = $signed({1'b0, sin_in[LOW_W-1:0]});

    // split partial products, recombined in the next stage
    always_ff @(posedge aclk) begin
        if (adv) begin
            ac_hi_reg <= a_in * c_hi;
            bs_hi_reg <= b_in * s_hi;
            as_hi_reg <= a_in * s_hi;
            bc_hi_reg <= b_in * c_hi;
            ac_lo_reg <= a_in * c_lo;
            bs_lo_reg <= b_in * s_lo;
            as_lo_reg <= a_in * s_lo;
            bc_lo_reg <= b_in * c_lo;
            p_d1_reg  <= p_in;
        end
    end

    assign ta_next = (RW'(ac_hi_reg - bs_hi_reg) <<< LOW_W)
                   + RW'(ac_lo_reg) - RW'(bs_lo_reg) + RND;
    assign tb_next = (RW'(as_hi_reg + bc_hi_reg) <<< LOW_W)
                   + RW'(as_lo_reg) + RW'(bc_lo_reg) + RND;

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_out_reg <= ta_next[30+CW-1:30];
            b_out_reg <= tb_next[30+CW-1:30];
            p_out_reg <= p_d1_reg;
        end
    end

    assign a_out = a_out_reg;
    assign b_out = b_out_reg;
    assign p_out = p_out_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rotate_and_project_vertex.sv =====
// ----------------------------------------------------------------------------
// rotate_and_project_vertex: rotate a Q4.12 point about z, x, y and project
// Perspective divide and viewport mapping, saturated 16-bit pixel output.
// ----------------------------------------------------------------------------
//  channel  dir  handshake             payload
//  s_       in   s_tvalid / s_tready   point_x, point_y, point_z
//  m_       out  m_tvalid / m_tready   screen_x, screen_y; behind_camera in tuser
//  cfg_     in   cfg_valid / cfg_ready register index and write data
//
//  one point per cycle unless the CORDIC unit is busy or the output buffer is full
//  (25 pipeline stages, 16 of them the divider, plus the output buffer)
//  after reset and after any angle write the CORDIC unit recomputes all three angles
//  (each a load step and 24 CORDIC steps) with s_tready low
//  a two-entry output buffer takes the last stage; the pipe halts only when it is full
// ----------------------------------------------------------------------------
`default_nettype none

module rotate_and_project_vertex #(
    parameter int COORD_FRAC_BITS = rpv_pkg::COORD_FRAC_BITS_DEF,
    parameter int ANGLE_BITS      = rpv_pkg::ANGLE_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // point_x, point_y, point_z
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // screen_x, screen_y
    output logic [0:0]       m_tuser,   // behind_camera
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import rpv_pkg::*;

    localparam int LAT    = 25;
    localparam int DIVS   = 16;
    localparam int QW     = OUT_W - 1;
    localparam int XDW    = CW + DIST_W + 1;
    localparam int DENW   = CW + 1 + DIST_W;
    localparam int TXW    = XDW + SCR_W + 3;
    localparam int DIVW   = TXW;
    localparam logic [ANG_W-1:0] AMASK =
        (ANGLE_BITS >= ANG_W) ? {ANG_W{1'b1}} : ANG_W'((1 << ANGLE_BITS) - 1);
    localparam logic signed [CW:0] ONE_EXT = (CW+1)'(1) <<< COORD_FRAC_BITS;

    // configuration
    logic [ANG_W-1:0]  ang_z_reg, ang_x_reg, ang_y_reg;
    logic [DIST_W-1:0] dist_reg, plane_reg, pe_reg;
    logic [SCR_W-1:0]  scr_w_reg, scr_h_reg, m_reg;
    logic [SCR_W-2:0]  hw_reg, hh_reg;
    logic              cfg_fire, ang_write;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_comb begin
        ang_write = cfg_fire && (cfg_index inside {CFG_ANGLE_Z, CFG_ANGLE_X, CFG_ANGLE_Y});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ang_z_reg <= '0;
            ang_x_reg <= '0;
            ang_y_reg <= '0;
            dist_reg  <= DIST_W'(4096);
            plane_reg <= DIST_W'(4096);
            scr_w_reg <= SCR_W'(640);
            scr_h_reg <= SCR_W'(480);
        end else if (cfg_fire) begin
            case (cfg_index)
                CFG_ANGLE_Z:    ang_z_reg <= cfg_data & AMASK;
                CFG_ANGLE_X:    ang_x_reg <= cfg_data & AMASK;
                CFG_ANGLE_Y:    ang_y_reg <= cfg_data & AMASK;
                CFG_PROJ_DIST:  dist_reg  <= cfg_data[DIST_W-1:0];
                CFG_PLANE_SIZE: plane_reg <= cfg_data[DIST_W-1:0];
                CFG_SCR_WIDTH:  scr_w_reg <= cfg_data[SCR_W-1:0];
                CFG_SCR_HEIGHT: scr_h_reg <= cfg_data[SCR_W-1:0];
                default: ;
            endcase
        end
    end

    // derived viewport terms, settle long before a point reaches them
    always_ff @(posedge aclk) begin
        pe_reg <= (plane_reg == '0) ? DIST_W'(1) : plane_reg;
        m_reg  <= (scr_w_reg < scr_h_reg) ? scr_w_reg : scr_h_reg;
        hw_reg <= scr_w_reg[SCR_W-1:1];
        hh_reg <= scr_h_reg[SCR_W-1:1];
    end

    // sine / cosine
    logic  busy;
    trig_t trig;

    rpv_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sincos (
        .aclk    (aclk),
        .aresetn (aresetn),
        .restart (ang_write),
        .angle_z (ang_z_reg),
        .angle_x (ang_x_reg),
        .angle_y (ang_y_reg),
        .busy    (busy),
        .trig    (trig)
    );

    // pipeline control
    logic [1:0]     ocnt_reg, ocnt_next;
    logic           adv, s_fire, push, pop;
    logic [LAT-1:0] vld_reg;

    assign adv      = (ocnt_reg != 2'd2);
    assign s_tready = adv && !busy;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], s_fire};
        end
    end

    // input stage
    logic signed [CW-1:0] x0_reg, y0_reg, z0_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            x0_reg <= CW'($signed(s_tdata[15:0]));
            y0_reg <= CW'($signed(s_tdata[31:16]));
            z0_reg <= CW'($signed(s_tdata[47:32]));
        end
    end

    // rotations: about z, then x, then y
    logic signed [CW-1:0] x1, y1, z1, x2, y2, z2, x3, y3, z3;

    rpv_rot u_rot_z (
        .aclk (aclk), .adv (adv),
        .a_in (x0_reg), .b_in (y0_reg), .p_in (z0_reg),
        .cos_in (trig.cos_z), .sin_in (trig.sin_z),
        .a_out (x1), .b_out (y1), .p_out (z1)
    );

    rpv_rot u_rot_x (
        .aclk (aclk), .adv (adv),
        .a_in (y1), .b_in (z1), .p_in (x1),
        .cos_in (trig.cos_x), .sin_in (trig.sin_x),
        .a_out (y2), .b_out (z2), .p_out (x2)
    );

    rpv_rot u_rot_y (
        .aclk (aclk), .adv (adv),
        .a_in (z2), .b_in (x2), .p_in (y2),
        .cos_in (trig.cos_y), .sin_in (trig.sin_y),
        .a_out (z3), .b_out (x3), .p_out (y3)
    );

    // camera shift and first products
    logic signed [CW:0]     zs;
    logic [CW:0]            dmag;
    logic signed [DIST_W:0] dist_s;
    logic signed [XDW-1:0]  yprod;
    logic signed [XDW-1:0]  xd_reg, yd_reg;
    logic [DENW-1:0]        den1_reg;
    logic                   bh1_reg;

    assign zs     = {z3[CW-1], z3} - ONE_EXT;
    assign dmag   = -zs;
    assign dist_s = $signed({1'b0, dist_reg});
    assign yprod  = y3 * dist_s;

    always_ff @(posedge aclk) begin
        if (adv) begin
            xd_reg   <= x3 * dist_s;
            yd_reg   <= -yprod;
            den1_reg <= dmag * pe_reg;
            bh1_reg  <= !zs[CW];
        end
    end

    // numerators with the centre offset folded in
    logic signed [SCR_W:0]  m_s;
    logic signed [SCR_W-1:0] hw_s, hh_s;
    logic signed [DENW:0]   den_s;
    logic signed [TXW-1:0]  tx_next, ty_next, tx_reg, ty_reg;
    logic [DENW-1:0]        den2_reg;
    logic                   bh2_reg;

    assign m_s     = $signed({1'b0, m_reg});
    assign hw_s    = $signed({1'b0, hw_reg});
    assign hh_s    = $signed({1'b0, hh_reg});
    assign den_s   = $signed({1'b0, den1_reg});
    assign tx_next = xd_reg * m_s + hw_s * den_s;
    assign ty_next = yd_reg * m_s + hh_s * den_s;

    always_ff @(posedge aclk) begin
        if (adv) begin
            tx_reg   <= tx_next;
            ty_reg   <= ty_next;
            den2_reg <= den1_reg;
            bh2_reg  <= bh1_reg;
        end
    end

    // divider: overflow check, then one quotient bit per stage
    logic [DIVW-1:0] rx_reg [DIVS];
    logic [DIVW-1:0] ry_reg [DIVS];
    logic [QW-1:0]   qx_reg [DIVS];
    logic [QW-1:0]   qy_reg [DIVS];
    logic [DENW-1:0] dd_reg [DIVS];
    logic [DIVS-1:0] nx_reg, ny_reg, ox_reg, oy_reg, bh_reg;

    logic [DIVW-1:0] magx, magy, lim0;

    assign magx = tx_reg[TXW-1] ? DIVW'(-tx_reg) : DIVW'(tx_reg);
    assign magy = ty_reg[TXW-1] ? DIVW'(-ty_reg) : DIVW'(ty_reg);
    assign lim0 = DIVW'(den2_reg) << QW;

    always_ff @(posedge aclk) begin
        if (adv) begin
            rx_reg[0] <= magx;
            ry_reg[0] <= magy;
            qx_reg[0] <= '0;
            qy_reg[0] <= '0;
            dd_reg[0] <= den2_reg;
            nx_reg[0] <= tx_reg[TXW-1];
            ny_reg[0] <= ty_reg[TXW-1];
            ox_reg[0] <= (magx >= lim0);
            oy_reg[0] <= (magy >= lim0);
            bh_reg[0] <= bh2_reg;
        end
    end

    for (genvar j = 1; j < DIVS; j++) begin : g_div
        localparam int B = DIVS - 1 - j;
        logic [DIVW-1:0] trial;
        logic            gex, gey;

        assign trial = DIVW'(dd_reg[j-1]) << B;
        assign gex   = rx_reg[j-1] >= trial;
        assign gey   = ry_reg[j-1] >= trial;

        always_ff @(posedge aclk) begin
            if (adv) begin
                rx_reg[j] <= gex ? rx_reg[j-1] - trial : rx_reg[j-1];
                ry_reg[j] <= gey ? ry_reg[j-1] - trial : ry_reg[j-1];
                qx_reg[j] <= qx_reg[j-1] | (QW'(gex) << B);
                qy_reg[j] <= qy_reg[j-1] | (QW'(gey) << B);
                dd_reg[j] <= dd_reg[j-1];
                nx_reg[j] <= nx_reg[j-1];
                ny_reg[j] <= ny_reg[j-1];
                ox_reg[j] <= ox_reg[j-1];
                oy_reg[j] <= oy_reg[j-1];
                bh_reg[j] <= bh_reg[j-1];
            end
        end
    end

    // sign, saturation and the behind-camera case
    logic signed [OUT_W-1:0] sx, sy;
    logic                    bh_out;

    always_comb begin
        if (ox_reg[DIVS-1]) begin
            sx = nx_reg[DIVS-1] ? OUT_W'(16'sh8000) : OUT_W'(16'sh7fff);
        end else begin
            sx = nx_reg[DIVS-1] ? -$signed({1'b0, qx_reg[DIVS-1]})
                                : $signed({1'b0, qx_reg[DIVS-1]});
        end
        if (oy_reg[DIVS-1]) begin
            sy = ny_reg[DIVS-1] ? OUT_W'(16'sh8000) : OUT_W'(16'sh7fff);
        end else begin
            sy = ny_reg[DIVS-1] ? -$signed({1'b0, qy_reg[DIVS-1]})
                                : $signed({1'b0, qy_reg[DIVS-1]});
        end
        bh_out = bh_reg[DIVS-1];
        if (bh_out) begin
            sx = '0;
            sy = '0;
        end
    end

    // two-entry output buffer
    logic [2*OUT_W:0] obuf_reg [2];
    logic             wptr_reg, rptr_reg;

    assign push = adv && vld_reg[LAT-1];
    assign pop  = m_tvalid && m_tready;

    always_comb begin
        ocnt_next = ocnt_reg;
        case ({push, pop})
            2'b10:   ocnt_next = ocnt_reg + 2'd1;
            2'b01:   ocnt_next = ocnt_reg - 2'd1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ocnt_reg <= '0;
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
        end else begin
            ocnt_reg <= ocnt_next;
            if (push) begin
                wptr_reg <= !wptr_reg;
            end
            if (pop) begin
                rptr_reg <= !rptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            obuf_reg[wptr_reg] <= {bh_out, sy, sx};
        end
    end

    assign m_tvalid = (ocnt_reg != 2'd0);
    assign m_tdata  = obuf_reg[rptr_reg][2*OUT_W-1:0];
    assign m_tuser  = obuf_reg[rptr_reg][2*OUT_W];

endmodule

`default_nettype wire

// ===== tb/sv/rotate_and_project_vertex_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotate_and_project_vertex_test: self-checking bench for the vertex pipeline
// Streams points through the block under many register settings and checks
// each result against a bit-exact CORDIC rotation and perspective predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module rotate_and_project_vertex_test;
    import rpv_pkg::*;

    localparam logic [2:0] CFG_NONE = 3'd7;  // unused index, write is dropped
    localparam int FRAC = COORD_FRAC_BITS_DEF;

    typedef struct packed {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic               behind;
    } pixel_t;

    typedef struct packed {
        logic [2:0]  idx;
        logic [15:0] data;
    } reg_write_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    rotate_and_project_vertex dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // shadow copy of the register file
    logic [15:0] ang_z, ang_x, ang_y;
    logic [14:0] proj_dist, plane;
    logic [12:0] scr_w, scr_h;

    logic [47:0]  point_q[$];
    reg_write_t   write_q[$];
    pixel_t       pixel_q[$];
    bit           calm = 1'b0;
    int           n_points = 0, n_pixels = 0, n_behind = 0, n_errors = 0, n_settings = 0;

    function automatic longint turn_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void sin_cos(input logic [15:0] ang, output longint c, output longint s);
        logic [31:0] a;
        longint x, y, z, dx, dy;
        a = {ang, 16'b0};
        z = longint'(a[29:0]);
        x = 652032874;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = turn_shift(y, i);
            dy = turn_shift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(atan_turn(i[4:0]));
            end else begin
                x += dx; y -= dy; z += longint'(atan_turn(i[4:0]));
            end
        end
        case (a[31:30])
            2'd0:    begin c = x;  s = y;  end
            2'd1:    begin c = -y; s = x;  end
            2'd2:    begin c = -x; s = -y; end
            default: begin c = y;  s = -x; end
        endcase
    endfunction

    function automatic longint round30(longint v);
        return (v + (longint'(1) <<< 29)) >>> 30;
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic pixel_t project_point(logic [47:0] p);
        longint x, y, z, c, s, nx, ny, nz, d, den, m, hw, hh, tx, ty;
        pixel_t r;
        x = longint'($signed(p[15:0]));
        y = longint'($signed(p[31:16]));
        z = longint'($signed(p[47:32]));
        sin_cos(ang_z, c, s);
        nx = round30(x * c - y * s);
        ny = round30(x * s + y * c);
        x = nx; y = ny;
        sin_cos(ang_x, c, s);
        ny = round30(y * c - z * s);
        nz = round30(y * s + z * c);
        y = ny; z = nz;
        sin_cos(ang_y, c, s);
        nx = round30(z * s + x * c);
        nz = round30(z * c - x * s);
        x = nx; z = nz;
        z -= longint'(1) <<< FRAC;
        r = '0;
        if (z >= 0) begin
            r.behind = 1'b1;
            return r;
        end
        d = -z;
        den = d * ((plane != 0) ? longint'(plane) : 1);
        m = (scr_w < scr_h) ? longint'(scr_w) : longint'(scr_h);
        hw = longint'(scr_w / 2);
        hh = longint'(scr_h / 2);
        tx = x * longint'(proj_dist) * m + hw * den;
        ty = -y * longint'(proj_dist) * m + hh * den;
        r.sx = clamp16(tx / den);
        r.sy = clamp16(ty / den);
        return r;
    endfunction

    // point driver, predicts at the accepting edge
    always @(posedge aclk) begin
        logic        nv;
        logic [47:0] nd;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            nv = s_tvalid;
            nd = s_tdata;
            if (s_tvalid && s_tready) begin
                pixel_q.push_back(project_point(s_tdata));
                n_points++;
                nv = 1'b0;
            end
            if (!nv && point_q.size() > 0 && (calm || $urandom_range(99) >= 7)) begin
                nv = 1'b1;
                nd = point_q.pop_front();
            end
            s_tvalid <= nv;
            s_tdata  <= nd;
        end
    end

    // register write driver, keeps the shadow copy in step
    always @(posedge aclk) begin
        logic       nv;
        reg_write_t w;
        if (!aresetn) begin
            cfg_valid <= 1'b0;
            ang_z = '0; ang_x = '0; ang_y = '0;
            proj_dist = 15'd4096; plane = 15'd4096;
            scr_w = 13'd640; scr_h = 13'd480;
        end else begin
            nv = cfg_valid;
            w = {cfg_index, cfg_data};
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ANGLE_Z:    ang_z = cfg_data;
                    CFG_ANGLE_X:    ang_x = cfg_data;
                    CFG_ANGLE_Y:    ang_y = cfg_data;
                    CFG_PROJ_DIST:  proj_dist = cfg_data[14:0];
                    CFG_PLANE_SIZE: plane = cfg_data[14:0];
                    CFG_SCR_WIDTH:  scr_w = cfg_data[12:0];
                    CFG_SCR_HEIGHT: scr_h = cfg_data[12:0];
                    default: ;
                endcase
                nv = 1'b0;
            end
            if (!nv && write_q.size() > 0 && (calm || $urandom_range(99) >= 7)) begin
                nv = 1'b1;
                w = write_q.pop_front();
            end
            cfg_valid <= nv;
            cfg_index <= w.idx;
            cfg_data  <= w.data;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        pixel_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_pixels++;
                if (pixel_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected beat: x=%0d y=%0d behind=%0b",
                                 $signed(m_tdata[15:0]), $signed(m_tdata[31:16]), m_tuser);
                end else begin
                    want = pixel_q.pop_front();
                    if (want.behind) n_behind++;
                    if (m_tdata[15:0] !== want.sx || m_tdata[31:16] !== want.sy ||
                        m_tuser[0] !== want.behind) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display({"mismatch beat %0d: want x=%0d y=%0d b=%0b, ",
                                      "got x=%0d y=%0d b=%0b"},
                                     n_pixels, want.sx, want.sy, want.behind,
                                     $signed(m_tdata[15:0]), $signed(m_tdata[31:16]), m_tuser);
                    end
                end
            end
            m_tready <= calm || ($urandom_range(99) >= 7);
        end
    end

    task automatic add_point(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
        point_q.push_back({z, y, x});
    endtask

    task automatic drain();
        while (point_q.size() > 0 || s_tvalid || pixel_q.size() > 0 || write_q.size() > 0
               || cfg_valid)
            @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic load_setting(input logic [15:0] az, input logic [15:0] ax,
                                input logic [15:0] ay, input logic [15:0] d,
                                input logic [15:0] p, input logic [15:0] w,
                                input logic [15:0] h);
        drain();
        write_q.push_back({CFG_ANGLE_Z, az});
        write_q.push_back({CFG_ANGLE_X, ax});
        write_q.push_back({CFG_ANGLE_Y, ay});
        write_q.push_back({CFG_PROJ_DIST, d});
        write_q.push_back({CFG_PLANE_SIZE, p});
        write_q.push_back({CFG_SCR_WIDTH, w});
        write_q.push_back({CFG_SCR_HEIGHT, h});
        n_settings++;
        drain();
    endtask

    task automatic random_points(input int n);
        logic [15:0] x, y, z;
        for (int i = 0; i < n; i++) begin
            x = 16'($urandom);
            y = 16'($urandom);
            z = 16'($urandom);
            case ($urandom_range(3))
                0: ;  // full range
                1: begin  // near the camera axis, mostly in front
                    x = $signed(x) >>> 3; y = $signed(y) >>> 3;
                    z = -16'sd1 - (z & 16'h3fff);
                end
                default: begin
                    x = $signed(x) >>> $urandom_range(6);
                    y = $signed(y) >>> $urandom_range(6);
                    z = z | 16'h8000;
                end
            endcase
            add_point(x, y, z);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset values, field extremes and the camera boundary
        add_point(16'h0000, 16'h0000, 16'h0000);
        add_point(16'h0000, 16'h0000, 16'h1000);   // exactly at the camera
        add_point(16'h0000, 16'h0000, 16'h0fff);   // just in front, smallest denominator
        add_point(16'h7fff, 16'h7fff, 16'h0fff);
        add_point(16'h8000, 16'h8000, 16'h0fff);
        add_point(16'h7fff, 16'h8000, 16'h8000);
        add_point(16'h8000, 16'h7fff, 16'h8000);
        add_point(16'h7fff, 16'h7fff, 16'h7fff);
        add_point(16'h8000, 16'h8000, 16'h8000);
        add_point(16'hffff, 16'hffff, 16'hffff);
        add_point(16'h1000, 16'hf000, 16'he000);
        add_point(16'h0001, 16'hffff, 16'hf000);
        drain();

        write_q.push_back({CFG_NONE, 16'hffff});
        load_setting(16'h4000, 16'h8000, 16'hc000, 16'h7fff, 16'h0001, 16'd4096, 16'd4096);
        add_point(16'h1000, 16'h1000, 16'hf000);
        add_point(16'h8000, 16'h7fff, 16'h0000);
        add_point(16'h7fff, 16'h8000, 16'h8000);
        load_setting(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        add_point(16'h1000, 16'h1000, 16'hf000);
        add_point(16'h8000, 16'h8000, 16'h8000);
        // zero registers: centre point, unit plane, empty viewport
        load_setting(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd1);
        add_point(16'h1000, 16'h2000, 16'hf000);
        add_point(16'h7fff, 16'h8000, 16'h8000);

        load_setting(16'h2000, 16'h1000, 16'h0800, 16'd4096, 16'd4096, 16'd640, 16'd480);
        calm = 1'b1;
        random_points(250);
        drain();
        calm = 1'b0;
        random_points(200);

        for (int k = 0; k < 7; k++) begin
            load_setting(16'($urandom), 16'($urandom), 16'($urandom),
                         (k == 0) ? 16'd1 : 16'($urandom_range(1, 32767)),
                         (k == 1) ? 16'd32767 : 16'($urandom_range(1, 32767)),
                         (k == 2) ? 16'd1 : 16'($urandom_range(1, 4096)),
                         (k == 3) ? 16'd1 : 16'($urandom_range(1, 4096)));
            random_points(205);
        end
        drain();

        $display("%0d points over %0d register settings, %0d results, %0d behind camera",
                 n_points, n_settings, n_pixels, n_behind);
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout with %0d results outstanding", pixel_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/rpv_pkg.sv
hw/rtl/rpv_sincos.sv
hw/rtl/rpv_rot.sv
hw/rtl/rotate_and_project_vertex.sv
tb/sv/rotate_and_project_vertex_test.sv
